FILE: hdl/llos_pkg.sv
// ----------------------------------------------------------------------------
// llos_pkg
// Shared types and constants for the label line occupancy scan.
// ----------------------------------------------------------------------------
`default_nettype none

package llos_pkg;

	localparam int MAX_LINES   = 64;
	localparam int MAX_COLUMNS = 128;
	localparam int LINE_W      = $clog2(MAX_LINES);
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int BM_ADDR_W   = LINE_W + COL_W;

	// register indexes
	localparam logic [1:0] REG_LINES   = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_MASK    = 2'd2;

	// reset values
	localparam logic [6:0] LINES_RST   = 7'd64;
	localparam logic [7:0] COLUMNS_RST = 8'd128;
	localparam logic [7:0] MASK_RST    = 8'h19;  // ball | field | white

	// line classes
	localparam logic [1:0] CLS_BOUNDARY = 2'd0;
	localparam logic [1:0] CLS_FREE     = 2'd1;
	localparam logic [1:0] CLS_BLOCKED  = 2'd2;

	typedef struct packed {
		logic [7:0] pixel_label;
		logic       frame_start;
	} pixel_t;

	typedef struct packed {
		logic [5:0] line_index;
		logic [7:0] free_length;
		logic [1:0] line_class;
		logic       last_line;
	} result_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [6:0] nl;
		logic [7:0] nc;
		logic [7:0] mask;
	} cfg_t;

	typedef struct packed {
		logic [7:0] upper;
		logic [7:0] lower;
	} cnt_pair_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic              clr;
		logic [LINE_W-1:0] addr;
		cnt_pair_t         wr_data;
	} cnt_req_t;

	typedef struct packed {
		logic                 rd_en;
		logic                 wr_en;
		logic [BM_ADDR_W-1:0] addr;
		logic                 wr_data;
	} bm_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIX,
		ST_EV_RD,
		ST_EV_CNT,
		ST_SRCH_RD,
		ST_SRCH_CHK
	} ctrl_state_t;

endpackage

`default_nettype wire

FILE: hdl/llos_bitmap.sv
// ----------------------------------------------------------------------------
// llos_bitmap
// One free bit per pixel, column-major, single port with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module llos_bitmap (
	input  wire logic            clk,
	input  wire llos_pkg::bm_req_t req,
	output logic                 rd_data
);
	import llos_pkg::*;

	logic mem [MAX_LINES*MAX_COLUMNS];
	logic rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: hdl/llos_counts.sv
// ----------------------------------------------------------------------------
// llos_counts
// Per-line half counts in a memory; per-line valid bits give zero after clear.
// ----------------------------------------------------------------------------
`default_nettype none

module llos_counts (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire llos_pkg::cnt_req_t  req,
	output llos_pkg::cnt_pair_t      rd_data
);
	import llos_pkg::*;

	cnt_pair_t              mem [MAX_LINES];
	cnt_pair_t              rd_data_q;
	logic [MAX_LINES-1:0]   valid_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.addr] <= 1'b1;
			end
			// a clear in the same cycle wins over the stored valid bit
			if (req.rd_en) begin
				rd_vld_q <= req.clr ? 1'b0 : valid_q[req.addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: hdl/llos_ctrl.sv
// ----------------------------------------------------------------------------
// llos_ctrl
// Sequencer: pixel intake, count update, per-line evaluation and search.
// ----------------------------------------------------------------------------
`default_nettype none

module llos_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire llos_pkg::cfg_t      cfg,
	input  wire logic               start,
	input  wire llos_pkg::pixel_t    pixel,
	output logic                    busy,
	output llos_pkg::cnt_req_t       cnt_req,
	input  wire llos_pkg::cnt_pair_t cnt_rdata,
	output llos_pkg::bm_req_t        bm_req,
	input  wire logic               bm_rdata,
	output logic                    result_strobe,
	output llos_pkg::result_t        result
);
	import llos_pkg::*;

	ctrl_state_t       state_q, state_d;
	logic [LINE_W-1:0] line_pos_q, pix_line_q, idx_q;
	logic [COL_W-1:0]  col_pos_q;
	logic              pix_free_q, pix_upper_q, pix_eof_q;
	logic [7:0]        pos_q;
	logic              res_strobe_q;
	result_t           res_q;

	logic              accept;
	logic [LINE_W-1:0] li_eff;
	logic [COL_W-1:0]  co_eff;
	logic              is_free, is_upper, line_more, col_more, eof;
	logic [6:0]        half;
	logic [8:0]        n_sum, sub_b, diff;
	logic              last_idx;
	logic              emit, go_search;
	logic [7:0]        emit_len;
	logic [1:0]        emit_cls;
	logic [7:0]        sel_cnt, inc_cnt;
	cnt_pair_t         new_pair;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign li_eff    = pixel.frame_start ? '0 : line_pos_q;
	assign co_eff    = pixel.frame_start ? '0 : col_pos_q;
	assign is_free   = |(pixel.pixel_label & cfg.mask);
	assign half      = cfg.nc[7:1];
	assign is_upper  = co_eff < half;
	assign line_more = ({1'b0, li_eff} + 7'd1) < cfg.nl;
	assign col_more  = ({1'b0, co_eff} + 8'd1) < cfg.nc;
	assign eof       = !line_more && !col_more;
	assign last_idx  = ({1'b0, idx_q} + 7'd1) >= cfg.nl;

	assign n_sum = {1'b0, cnt_rdata.upper} + {1'b0, cnt_rdata.lower};

	// shared subtractor: start column in EV_CNT, run length in search states
	assign sub_b = (state_q == ST_EV_CNT) ? n_sum : {1'b0, pos_q};
	assign diff  = {1'b0, cfg.nc} - sub_b + 9'd1;

	// count update for the pixel taken last cycle, saturating
	always_comb begin
		sel_cnt  = pix_upper_q ? cnt_rdata.upper : cnt_rdata.lower;
		inc_cnt  = (sel_cnt == 8'hFF) ? sel_cnt : sel_cnt + 8'd1;
		new_pair = cnt_rdata;
		if (pix_free_q) begin
			if (pix_upper_q) begin
				new_pair.upper = inc_cnt;
			end else begin
				new_pair.lower = inc_cnt;
			end
		end
	end

	// outputs of the sequencer
	always_comb begin
		cnt_req   = '0;
		bm_req    = '0;
		emit      = 1'b0;
		go_search = 1'b0;
		emit_len  = '0;
		emit_cls  = CLS_BOUNDARY;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cnt_req.rd_en  = 1'b1;
					cnt_req.addr   = li_eff;
					cnt_req.clr    = pixel.frame_start;
					bm_req.wr_en   = 1'b1;
					bm_req.addr    = {co_eff, li_eff};
					bm_req.wr_data = is_free;
				end
			end
			ST_PIX: begin
				cnt_req.wr_en   = 1'b1;
				cnt_req.addr    = pix_line_q;
				cnt_req.wr_data = new_pair;
			end
			ST_EV_RD: begin
				cnt_req.rd_en = 1'b1;
				cnt_req.addr  = idx_q;
			end
			ST_EV_CNT: begin
				if (cnt_rdata.upper == {1'b0, half} || n_sum >= {1'b0, cfg.nc}) begin
					emit     = 1'b1;
					emit_len = cfg.nc;
					emit_cls = CLS_FREE;
				end else if (n_sum == '0) begin
					emit     = 1'b1;
					emit_cls = CLS_BLOCKED;
				end else begin
					go_search = 1'b1;
				end
			end
			ST_SRCH_RD: begin
				// past the last column ends the search without a bitmap read
				if (pos_q >= cfg.nc) begin
					emit     = 1'b1;
					emit_len = diff[7:0];
				end else begin
					bm_req.rd_en = 1'b1;
					bm_req.addr  = {pos_q[COL_W-1:0], idx_q};
				end
			end
			ST_SRCH_CHK: begin
				if (bm_rdata) begin
					emit     = 1'b1;
					emit_len = diff[7:0];
				end
			end
			default: begin
			end
		endcase
		if (emit && last_idx) begin
			cnt_req.clr = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_PIX;
			end
			ST_PIX: begin
				state_d = pix_eof_q ? ST_EV_RD : ST_IDLE;
			end
			ST_EV_RD: begin
				state_d = ST_EV_CNT;
			end
			ST_EV_CNT: begin
				if (emit) state_d = last_idx ? ST_IDLE : ST_EV_RD;
				else state_d = ST_SRCH_RD;
			end
			ST_SRCH_RD: begin
				if (emit) state_d = last_idx ? ST_IDLE : ST_EV_RD;
				else state_d = ST_SRCH_CHK;
			end
			ST_SRCH_CHK: begin
				if (emit) state_d = last_idx ? ST_IDLE : ST_EV_RD;
				else state_d = ST_SRCH_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			line_pos_q   <= '0;
			col_pos_q    <= '0;
			idx_q        <= '0;
			pix_eof_q    <= 1'b0;
			res_strobe_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			res_strobe_q <= emit;
			if (accept) begin
				pix_eof_q <= eof;
				if (eof) begin
					line_pos_q <= '0;
					col_pos_q  <= '0;
				end else if (line_more) begin
					line_pos_q <= li_eff + 1'b1;
					col_pos_q  <= co_eff;
				end else begin
					line_pos_q <= '0;
					col_pos_q  <= co_eff + 1'b1;
				end
			end
			if (state_q == ST_PIX) begin
				idx_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_free_q  <= is_free;
			pix_upper_q <= is_upper;
			pix_line_q  <= li_eff;
		end
		if (go_search) begin
			pos_q <= diff[7:0];
		end else if (state_q == ST_SRCH_CHK && !emit) begin
			pos_q <= pos_q + 8'd1;
		end
		if (emit) begin
			res_q.line_index  <= idx_q;
			res_q.free_length <= emit_len;
			res_q.line_class  <= emit_cls;
			res_q.last_line   <= last_idx;
		end
	end

	assign result_strobe = res_strobe_q;
	assign result        = res_q;

endmodule

`default_nettype wire

FILE: hdl/label_line_occupancy_scan.sv
// ----------------------------------------------------------------------------
// label_line_occupancy_scan
// Counts free pixels per line over a column-major label frame and, after the
// last pixel, reports the free run at the end of every line.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------
//  pixel     start, busy               pixel_t  {pixel_label, frame_start}
//  result    result_strobe (no stall)  result_t {line_index, free_length,
//                                                line_class, last_line}
//  config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
//  Sequence: a pixel is accepted only while idle; busy is high the cycle after
//  start, for the read-modify-write of the per-line count memory. The last
//  pixel of a frame is followed by the line scan: per line a count read and
//  class decision, plus a bitmap read and check per column probed when a
//  boundary search runs and a final step when the search runs off the end of
//  the line (bitmap memory has one port, registered read). Results come one
//  per line, never in two adjacent cycles, in line order.
//  Reset: arst_n clears the sequencer, positions and count valid bits; the
//  config registers return to 64 lines, 128 columns, mask 0x19. No clearing
//  pass is needed. The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module label_line_occupancy_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// pixel intake
	input  wire logic              start,
	output logic                   busy,
	input  wire llos_pkg::pixel_t   pixel,
	// results
	output logic                   result_strobe,
	output llos_pkg::result_t       result,
	// register writes
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data
);
	import llos_pkg::*;

	logic [6:0] lines_q;
	logic [7:0] columns_q;
	logic [7:0] mask_q;
	cfg_t       cfg;
	cnt_req_t   cnt_req;
	cnt_pair_t  cnt_rdata;
	bm_req_t    bm_req;
	logic       bm_rdata;
	logic       cfg_xfer;

	// writes must only be issued while idle; the block does not enforce this, the port is always open
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q   <= LINES_RST;
			columns_q <= COLUMNS_RST;
			mask_q    <= MASK_RST;
		end else if (cfg_xfer) begin
			case (cfg_index)
				REG_LINES:   lines_q   <= cfg_data[6:0];
				REG_COLUMNS: columns_q <= cfg_data;
				REG_MASK:    mask_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// clamp lines to 1..MAX_LINES and columns to 2..MAX_COLUMNS
	always_comb begin
		if (lines_q == '0) begin
			cfg.nl = 7'd1;
		end else if (lines_q > 7'(MAX_LINES)) begin
			cfg.nl = 7'(MAX_LINES);
		end else begin
			cfg.nl = lines_q;
		end
		if (columns_q < 8'd2) begin
			cfg.nc = 8'd2;
		end else if (columns_q > 8'(MAX_COLUMNS)) begin
			cfg.nc = 8'(MAX_COLUMNS);
		end else begin
			cfg.nc = columns_q;
		end
		cfg.mask = mask_q;
	end

	llos_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.start         (start),
		.pixel         (pixel),
		.busy          (busy),
		.cnt_req       (cnt_req),
		.cnt_rdata     (cnt_rdata),
		.bm_req        (bm_req),
		.bm_rdata      (bm_rdata),
		.result_strobe (result_strobe),
		.result        (result)
	);

	llos_counts u_counts (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cnt_req),
		.rd_data (cnt_rdata)
	);

	llos_bitmap u_bitmap (
		.clk     (clk),
		.req     (bm_req),
		.rd_data (bm_rdata)
	);

endmodule

`default_nettype wire

FILE: hdl/llos_checker.sv
// ----------------------------------------------------------------------------
// llos_checker
// Port-level checks on the scan block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module llos_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire logic             result_strobe,
	input  wire llos_pkg::result_t result
);
	import llos_pkg::*;

	// a taken pixel always holds the block for its count update
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after pixel transfer");

	// every result needs a count read first, so strobes never touch
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("results in adjacent cycles");

	// more lines pending: block stays busy
	a_more_lines: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last_line |-> busy)
		else $error("idle before last line reported");

	// blocked lines report zero length
	a_blocked_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.line_class == CLS_BLOCKED |-> result.free_length == 8'd0)
		else $error("blocked line with nonzero length");

endmodule

bind label_line_occupancy_scan llos_checker u_llos_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.result        (result)
);

`default_nettype wire
